>>> rtl/rrf_pkg.sv
`default_nettype none

package rrf_pkg;

  // Field and datapath widths fixed by the beat formats
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 16;
  localparam int PIX_W     = 32;
  localparam int COL_W     = 17;  // shift + tap index, both 16 bit
  localparam int OCOL_W    = 12;
  localparam int ROW_W     = 12;
  localparam int IDX_W     = 24;
  localparam int PROD_W    = 25;  // signed 16 x unsigned 8
  localparam int ACC_W     = 41;  // up to 65535 products, exact
  localparam int Q_FRAC    = 14;
  localparam int ROUND_HALF = 1 << 13;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef logic [1:0] action_t;
  localparam action_t ACT_FILTER  = 2'd0;
  localparam action_t ACT_PIXEL   = 2'd1;
  localparam action_t ACT_COMPUTE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_WIDTH = 2'd2;

  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = 13'd4096;
  localparam logic [CFG_W-1:0] ROW_COUNT_RST  = 13'd1;
  localparam logic [CFG_W-1:0] DEST_WIDTH_RST = 13'd1;

  typedef struct packed {
    action_t            action;
    logic [13:0]        address;
    logic signed [15:0] filter_word;
    logic [31:0]        pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    logic [23:0] dest_index;
    logic        row_last;
  } out_beat_t;

  // Sideband that travels with each tap into the MAC
  typedef struct packed {
    logic clear;  // new output pixel: zero the accumulators
    logic tap;    // coefficient and pixel on the inputs are valid
    logic last;   // final token of this pixel
  } mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COUNT,
    ST_TAPS,
    ST_DRAIN
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/rrf_ram.sv
`default_nettype none

module rrf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rrf_mac.sv
`default_nettype none

module rrf_mac (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rrf_pkg::mac_ctl_t  ctl,
  input  wire logic signed [15:0] coef,
  input  wire logic [31:0]        pixel,
  output logic                    fin,
  output logic [31:0]             pixel_out
);

  localparam int AW = rrf_pkg::ACC_W;
  localparam int QF = rrf_pkg::Q_FRAC;

  logic signed [rrf_pkg::PROD_W-1:0] prod_r [4];
  logic signed [AW-1:0]              acc_r  [4];
  logic                              pv_r, pl_r, fin_r;

  // stage 1: product registers, stage 2: accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      pl_r  <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      pv_r  <= ctl.tap;
      pl_r  <= ctl.last;
      fin_r <= pl_r;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    logic signed [AW-1:0] rnd;
    logic [7:0]           chan;

    always_ff @(posedge clk) begin
      prod_r[c] <= coef * $signed({1'b0, pixel[8*c +: 8]});
      if (ctl.clear) begin
        acc_r[c] <= '0;
      end else if (pv_r) begin
        acc_r[c] <= acc_r[c] + AW'(prod_r[c]);
      end
    end

    // round half up, drop the Q14 fraction, clamp to a byte
    assign rnd = acc_r[c] + AW'(rrf_pkg::ROUND_HALF);

    always_comb begin
      if (rnd[AW-1]) begin
        chan = 8'd0;
      end else if (|rnd[AW-2:QF+8]) begin
        chan = rrf_pkg::CHAN_MAX;
      end else begin
        chan = rnd[QF+7:QF];
      end
    end

    assign pixel_out[8*c +: 8] = chan;
  end

  assign fin = fin_r;

endmodule

`default_nettype wire

>>> rtl/rgba_row_resample_filter_core.sv
`default_nettype none

// Horizontal pass of a separable RGBA resizer.
// Input beats (start/busy, in_data): action FILTER writes one 16-bit word of
// the packed filter table, PIXEL writes one 32-bit pixel of the row buffer,
// COMPUTE produces the next output pixel. A beat is taken on a clock edge
// with start high and busy low. Loads finish on that edge, never raising busy.
// A COMPUTE walks the table at the filter cursor: start shift, tap count T,
// then T Q14 coefficients, one tap per cycle through the filter RAM and row
// RAM read ports, into a 4-lane MAC (product stage, accumulate stage).
// The result beat appears on out_valid/out_data once the MAC has drained;
// busy falls on that same edge, so a compute request is not taken until
// the previous result is out. The tap count (RAM reads) sets the rate.
// out_valid is a one-cycle strobe; the receiver cannot stall it.
// cfg_we/cfg_index/cfg_wdata write src_width, row_count, dest_width; the user
// must write them while idle (not enforced); they take effect on next COMPUTE.
// Reset (rst_n low, synchronous) clears the cursor, output column and row
// counters and loads register defaults. The filter table and row buffer are
// not cleared: software loads them before use.
module rgba_row_resample_filter_core #(
  parameter int MAX_ROW_PIXELS = 4096,
  parameter int FILTER_WORDS   = 16384
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire rrf_pkg::in_beat_t                    in_data,
  output logic                                      out_valid,
  output rrf_pkg::out_beat_t                        out_data,
  input  wire logic                                 cfg_we,
  input  wire logic [rrf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [rrf_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int FA  = $clog2(FILTER_WORDS);
  localparam int RA  = $clog2(MAX_ROW_PIXELS);
  localparam int CW  = rrf_pkg::CFG_W;
  // largest count that a 13-bit register can ask for after the clamp
  localparam logic [CW-1:0] CNT_LIM =
    CW'((MAX_ROW_PIXELS > 8191) ? 8191 : MAX_ROW_PIXELS);

  rrf_pkg::seq_state_t state_r, state_nxt;

  logic [FA-1:0]                    cursor_r, cursor_nxt, cursor_inc;
  logic [rrf_pkg::COL_W-1:0]        col_r, col_nxt;
  logic                             col_ok_r, col_ok_nxt;
  logic [rrf_pkg::WORD_W-1:0]       rem_r, rem_nxt;
  logic                             issue_r, issue_nxt;
  logic                             issue_last_r, issue_last_nxt;
  logic [rrf_pkg::OCOL_W-1:0]       ocol_r, ocol_nxt;
  logic [rrf_pkg::ROW_W-1:0]        row_r, row_nxt;
  logic [rrf_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic                             last_r, last_nxt;
  logic [CW-1:0]                    src_width_r, row_count_r, dest_width_r;
  logic                             out_valid_r, out_valid_nxt;
  rrf_pkg::out_beat_t               out_r, out_nxt;

  logic                             accept, is_compute;
  logic                             filt_we, row_we;
  logic [FA-1:0]                    filt_waddr;
  logic [RA-1:0]                    row_waddr;
  logic [rrf_pkg::WORD_W-1:0]       filt_rdata;
  logic [rrf_pkg::PIX_W-1:0]        row_rdata;
  logic [CW-1:0]                    rows_lim, cols_lim;
  logic [rrf_pkg::IDX_W:0]          idx_full;
  logic                             col_in_row;
  rrf_pkg::mac_ctl_t                mac_ctl;
  logic                             mac_fin;
  logic [rrf_pkg::PIX_W-1:0]        mac_pixel;

  function automatic logic [CW-1:0] limit_cnt(input logic [CW-1:0] v);
    logic [CW-1:0] r;
    if (v == '0) begin
      r = CW'(1);
    end else if (v > CNT_LIM) begin
      r = CNT_LIM;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Input beat decode and RAM writes (loads complete on the accept edge)
  // ---------------------------------------------------------------------
  assign busy       = (state_r != rrf_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign is_compute = (in_data.action == rrf_pkg::ACT_COMPUTE);

  assign filt_we    = accept && (in_data.action == rrf_pkg::ACT_FILTER) &&
                      (32'(in_data.address) < 32'(FILTER_WORDS));
  assign row_we     = accept && (in_data.action == rrf_pkg::ACT_PIXEL) &&
                      (32'(in_data.address) < 32'(MAX_ROW_PIXELS));
  assign filt_waddr = FA'(in_data.address);
  assign row_waddr  = RA'(in_data.address);

  // Filter RAM always reads at the cursor, row RAM at the tap column
  rrf_ram #(
    .WIDTH (rrf_pkg::WORD_W),
    .DEPTH (FILTER_WORDS)
  ) u_filt_ram (
    .clk   (clk),
    .we    (filt_we),
    .waddr (filt_waddr),
    .wdata (in_data.filter_word),
    .raddr (cursor_r),
    .rdata (filt_rdata)
  );

  rrf_ram #(
    .WIDTH (rrf_pkg::PIX_W),
    .DEPTH (MAX_ROW_PIXELS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (in_data.pixel_in),
    .raddr (col_r[RA-1:0]),
    .rdata (row_rdata)
  );

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= rrf_pkg::SRC_WIDTH_RST;
      row_count_r  <= rrf_pkg::ROW_COUNT_RST;
      dest_width_r <= rrf_pkg::DEST_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrf_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        rrf_pkg::CFG_ROW_COUNT:  row_count_r  <= cfg_wdata;
        rrf_pkg::CFG_DEST_WIDTH: dest_width_r <= cfg_wdata;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign rows_lim = limit_cnt(row_count_r);
  assign cols_lim = limit_cnt(dest_width_r);

  // transposed destination: column * rows + row, kept to 24 bits
  assign idx_full = (rrf_pkg::IDX_W+1)'(ocol_r) * (rrf_pkg::IDX_W+1)'(rows_lim) +
                    (rrf_pkg::IDX_W+1)'(row_r);

  assign cursor_inc = (cursor_r == FA'(FILTER_WORDS - 1)) ? '0 : cursor_r + 1'b1;

  // taps at or past the row end read as zero
  assign col_in_row = (32'(col_r) < 32'(src_width_r)) &&
                      (32'(col_r) < 32'(MAX_ROW_PIXELS));

  // ---------------------------------------------------------------------
  // Sequencer
  //   IDLE : RAM already holds the shift word at the cursor on accept
  //   HEAD : shift arrives -> tap column; read tap count
  //   COUNT: tap count arrives; issue first tap or a bare end token
  //   TAPS : one coefficient / pixel read per cycle
  //   DRAIN: wait for the MAC, then post the result and step counters
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cursor_nxt     = cursor_r;
    col_nxt        = col_r;
    col_ok_nxt     = col_ok_r;
    rem_nxt        = rem_r;
    issue_nxt      = 1'b0;
    issue_last_nxt = 1'b0;
    ocol_nxt       = ocol_r;
    row_nxt        = row_r;
    idx_nxt        = idx_r;
    last_nxt       = last_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;

    unique case (state_r)
      rrf_pkg::ST_IDLE: begin
        if (accept && is_compute) begin
          cursor_nxt = cursor_inc;
          state_nxt  = rrf_pkg::ST_HEAD;
        end
      end

      rrf_pkg::ST_HEAD: begin
        col_nxt    = rrf_pkg::COL_W'(filt_rdata);
        cursor_nxt = cursor_inc;
        idx_nxt    = idx_full[rrf_pkg::IDX_W-1:0];
        last_nxt   = (CW'(ocol_r) + CW'(1)) >= cols_lim;
        state_nxt  = rrf_pkg::ST_COUNT;
      end

      rrf_pkg::ST_COUNT: begin
        if (filt_rdata == '0) begin
          // no taps: send just the end token
          issue_last_nxt = 1'b1;
          state_nxt      = rrf_pkg::ST_DRAIN;
        end else begin
          issue_nxt      = 1'b1;
          issue_last_nxt = (filt_rdata == rrf_pkg::WORD_W'(1));
          col_ok_nxt     = col_in_row;
          cursor_nxt     = cursor_inc;
          col_nxt        = col_r + 1'b1;
          rem_nxt        = filt_rdata - 1'b1;
          state_nxt      = (filt_rdata == rrf_pkg::WORD_W'(1)) ? rrf_pkg::ST_DRAIN
                                                              : rrf_pkg::ST_TAPS;
        end
      end

      rrf_pkg::ST_TAPS: begin
        issue_nxt      = 1'b1;
        issue_last_nxt = (rem_r == rrf_pkg::WORD_W'(1));
        col_ok_nxt     = col_in_row;
        cursor_nxt     = cursor_inc;
        col_nxt        = col_r + 1'b1;
        rem_nxt        = rem_r - 1'b1;
        if (rem_r == rrf_pkg::WORD_W'(1)) begin
          state_nxt = rrf_pkg::ST_DRAIN;
        end
      end

      rrf_pkg::ST_DRAIN: begin
        if (mac_fin) begin
          out_valid_nxt      = 1'b1;
          out_nxt.pixel_out  = mac_pixel;
          out_nxt.dest_index = idx_r;
          out_nxt.row_last   = last_r;
          if (last_r) begin
            // row done: rewind the table, next row
            ocol_nxt   = '0;
            cursor_nxt = '0;
            row_nxt    = ((CW'(row_r) + CW'(1)) >= rows_lim) ? '0 : row_r + 1'b1;
          end else begin
            ocol_nxt = ocol_r + 1'b1;
          end
          state_nxt = rrf_pkg::ST_IDLE;
        end
      end

      default: state_nxt = rrf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r     <= '0;
      ocol_r       <= '0;
      row_r        <= '0;
      issue_r      <= 1'b0;
      issue_last_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cursor_r     <= cursor_nxt;
      ocol_r       <= ocol_nxt;
      row_r        <= row_nxt;
      issue_r      <= issue_nxt;
      issue_last_r <= issue_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r    <= col_nxt;
    col_ok_r <= col_ok_nxt;
    rem_r    <= rem_nxt;
    idx_r    <= idx_nxt;
    last_r   <= last_nxt;
    out_r    <= out_nxt;
  end

  // ---------------------------------------------------------------------
  // MAC: RAM read data of the tap issued last cycle
  // ---------------------------------------------------------------------
  assign mac_ctl.clear = accept && is_compute;
  assign mac_ctl.tap   = issue_r;
  assign mac_ctl.last  = issue_last_r;

  rrf_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .coef      ($signed(filt_rdata)),
    .pixel     (col_ok_r ? row_rdata : '0),
    .fin       (mac_fin),
    .pixel_out (mac_pixel)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == rrf_pkg::ST_DRAIN))
    else $error("result beat without a finished compute");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

  a_compute_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_compute) |=> (state_r == rrf_pkg::ST_HEAD))
    else $error("accepted compute beat did not start the sequencer");

  a_taps_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rrf_pkg::ST_TAPS) |-> (rem_r != '0))
    else $error("tap loop running with no taps left");

  a_fin_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    mac_fin |-> (state_r == rrf_pkg::ST_DRAIN))
    else $error("MAC finished outside the drain state");

endmodule

`default_nettype wire

>>> sim/rrf_result_checker.sv
`timescale 1ns / 100ps

module rrf_result_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire rrf_pkg::in_beat_t             in_data,
  input  wire logic                          out_valid,
  input  wire rrf_pkg::out_beat_t            out_data,
  input  wire logic                          cfg_we,
  input  wire logic [rrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rrf_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                 mismatches,
  output int                                 outstanding
);

  localparam int FILTER_WORDS = 16384;
  localparam int ROW_PIXELS   = 4096;

  logic [15:0]                coef_table [FILTER_WORDS];
  logic [31:0]                row_pixels [ROW_PIXELS];
  logic [13:0]                cursor;
  logic [rrf_pkg::OCOL_W-1:0] out_col;
  logic [rrf_pkg::ROW_W-1:0]  row_num;
  logic [rrf_pkg::CFG_W-1:0]  src_width;
  logic [rrf_pkg::CFG_W-1:0]  row_count;
  logic [rrf_pkg::CFG_W-1:0]  dest_width;

  rrf_pkg::out_beat_t expected_pixels [$];

  // zero acts as one, anything past a full row saturates
  function automatic int clip_count(logic [rrf_pkg::CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > ROW_PIXELS) return ROW_PIXELS;
    return int'(v);
  endfunction

  // Walks one filter entry at the cursor and advances column/row state.
  function automatic rrf_pkg::out_beat_t resample_pixel();
    logic [15:0]        shift_w;
    logic [15:0]        tap_w;
    logic signed [15:0] coef;
    logic [31:0]        px;
    longint             lane_acc [4];
    longint             rnd;
    int                 col;
    int                 rows;
    int                 cols;
    logic [31:0]        flat_idx;
    logic               is_last;
    rrf_pkg::out_beat_t res;
    for (int c = 0; c < 4; c++) lane_acc[c] = 0;
    shift_w = coef_table[cursor];
    cursor  = cursor + 1'b1;
    tap_w   = coef_table[cursor];
    cursor  = cursor + 1'b1;
    for (int k = 0; k < int'(tap_w); k++) begin
      coef   = coef_table[cursor];
      cursor = cursor + 1'b1;
      col    = int'(shift_w) + k;
      px     = (col < src_width && col < ROW_PIXELS) ? row_pixels[col] : 32'd0;
      for (int c = 0; c < 4; c++)
        lane_acc[c] += longint'(coef) * longint'(px[8*c +: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      rnd = lane_acc[c] + rrf_pkg::ROUND_HALF;
      if (rnd < 0) res.pixel_out[8*c +: 8] = 8'd0;
      else if ((rnd >>> rrf_pkg::Q_FRAC) > rrf_pkg::CHAN_MAX)
        res.pixel_out[8*c +: 8] = rrf_pkg::CHAN_MAX;
      else res.pixel_out[8*c +: 8] = rnd[rrf_pkg::Q_FRAC +: 8];
    end
    rows     = clip_count(row_count);
    cols     = clip_count(dest_width);
    flat_idx = int'(out_col) * rows + int'(row_num);
    is_last  = (int'(out_col) + 1) >= cols;
    res.dest_index = flat_idx[rrf_pkg::IDX_W-1:0];
    res.row_last   = is_last;
    if (is_last) begin
      out_col = '0;
      cursor  = '0;
      row_num = (int'(row_num) + 1 >= rows) ? '0 : row_num + 1'b1;
    end else begin
      out_col = out_col + 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rrf_pkg::out_beat_t want;
    if (!rst_n) begin
      cursor     = '0;
      out_col    = '0;
      row_num    = '0;
      src_width  = rrf_pkg::SRC_WIDTH_RST;
      row_count  = rrf_pkg::ROW_COUNT_RST;
      dest_width = rrf_pkg::DEST_WIDTH_RST;
      expected_pixels.delete();
    end else begin
      if (out_valid) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected result beat: pixel_out %08h dest_index %0d",
                 out_data.pixel_out, out_data.dest_index);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_out !== want.pixel_out) begin
            $error("pixel_out: expected %08h, got %08h", want.pixel_out, out_data.pixel_out);
            mismatches++;
          end
          if (out_data.dest_index !== want.dest_index) begin
            $error("dest_index: expected %0d, got %0d", want.dest_index, out_data.dest_index);
            mismatches++;
          end
          if (out_data.row_last !== want.row_last) begin
            $error("row_last: expected %0b, got %0b", want.row_last, out_data.row_last);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          rrf_pkg::CFG_SRC_WIDTH:  src_width  = cfg_wdata;
          rrf_pkg::CFG_ROW_COUNT:  row_count  = cfg_wdata;
          rrf_pkg::CFG_DEST_WIDTH: dest_width = cfg_wdata;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_data.action)
          rrf_pkg::ACT_FILTER: coef_table[in_data.address] = in_data.filter_word;
          rrf_pkg::ACT_PIXEL: begin
            if (in_data.address < ROW_PIXELS) row_pixels[in_data.address] = in_data.pixel_in;
          end
          rrf_pkg::ACT_COMPUTE: expected_pixels.push_back(resample_pixel());
          default: ;
        endcase
      end
    end
    outstanding = expected_pixels.size();
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int FILTER_WORDS = 16384;
  localparam int ROW_PIXELS   = 4096;
  localparam int RANDOM_BEATS = 1480;
  // About 1500 beats; even at the longest idle, a slipped beat and a 16-tap
  // compute each, plus settling per phase, a run stays well inside the limit.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 8;   // idle margin before a config write

  localparam rrf_pkg::action_t ACT_NOP = 2'd3;                  // unused opcode
  localparam logic [rrf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unused register slot

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  rrf_pkg::in_beat_t             in_data;
  logic                          out_valid;
  rrf_pkg::out_beat_t            out_data;
  logic                          cfg_we;
  logic [rrf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rrf_pkg::CFG_W-1:0]     cfg_wdata;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int beats_sent  = 0;
  bit no_gaps     = 1'b0;

  // shift/taps of the entries loaded for the current phase, in column order
  int entry_shift [$];
  int entry_taps  [$];

  rgba_row_resample_filter_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rrf_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop if the handshake hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic rrf_pkg::in_beat_t make_beat(rrf_pkg::action_t act, logic [13:0] addr,
                                                  logic [15:0] word, logic [31:0] pix);
    rrf_pkg::in_beat_t b;
    b.action      = act;
    b.address     = addr;
    b.filter_word = word;
    b.pixel_in    = pix;
    return b;
  endfunction

  // pixels lean on the all-zero / all-ones corners now and then
  function automatic logic [31:0] random_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // style 0: realistic kernel taps, 1: Q14 extremes, 2: anything
  function automatic logic [15:0] pick_coef(int style);
    int v;
    case (style)
      0:       v = $urandom_range(0, 22000) - 2000;
      1:       v = $urandom_range(0, 1) ? 32767 : -32768;
      default: v = $urandom;
    endcase
    return v[15:0];
  endfunction

  // Sender idle: mostly back to back, sometimes a few cycles, rarely long.
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) n = 0;
    else if (r < 19) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 40);
    if (n > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Drive at the falling edge, hold until a rising edge sees busy low.
  task automatic send(input rrf_pkg::in_beat_t beat, input bit counted);
    sender_gap();
    @(negedge clk);
    start   <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (counted) beats_sent++;
  endtask

  // Occasionally slips in a beat the core must drop: the spare opcode or a
  // pixel column past the row buffer.
  task automatic send_item(input rrf_pkg::in_beat_t beat);
    if (!no_gaps && $urandom_range(0, 29) == 0) begin
      if ($urandom_range(0, 1))
        send(make_beat(ACT_NOP, 14'($urandom), 16'($urandom), $urandom), 1'b0);
      else
        send(make_beat(rrf_pkg::ACT_PIXEL, 14'($urandom_range(ROW_PIXELS, 16383)),
                       16'($urandom), $urandom), 1'b0);
    end
    send(beat, 1'b1);
  endtask

  task automatic load_word(input int addr, input logic [15:0] word);
    send_item(make_beat(rrf_pkg::ACT_FILTER, 14'(addr), word, $urandom));
  endtask

  task automatic load_pixel(input int col, input logic [31:0] pix);
    send_item(make_beat(rrf_pkg::ACT_PIXEL, 14'(col), 16'($urandom), pix));
  endtask

  // unused fields of a compute beat carry junk on purpose
  task automatic compute();
    send_item(make_beat(rrf_pkg::ACT_COMPUTE, 14'($urandom), 16'($urandom), $urandom));
  endtask

  // Block is idle once every predicted pixel is out and busy is low; give it
  // a few more cycles before touching config.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0 || busy) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [rrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rrf_pkg::CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int src, input int rows, input int cols);
    settle();
    write_reg(rrf_pkg::CFG_SRC_WIDTH, rrf_pkg::CFG_W'(src));
    write_reg(rrf_pkg::CFG_ROW_COUNT, rrf_pkg::CFG_W'(rows));
    write_reg(rrf_pkg::CFG_DEST_WIDTH, rrf_pkg::CFG_W'(cols));
  endtask

  // Packs one entry per output column from word 0: shift, tap count, coefs.
  // Shifts mostly lie between 0 and just past src_width (capped at the row
  // buffer); some run past the row buffer or wrap as large unsigned values.
  task automatic load_entries(input int cols, input int src);
    int addr;
    int reach;
    int sh;
    int tp;
    int style;
    int r;
    addr  = 0;
    reach = (src > ROW_PIXELS) ? ROW_PIXELS : src;
    entry_shift.delete();
    entry_taps.delete();
    for (int j = 0; j < cols; j++) begin
      r = $urandom_range(0, 9);
      if (r < 7) sh = $urandom_range(0, reach + 2);
      else if (r == 7) sh = ROW_PIXELS - $urandom_range(0, 8);
      else if (r == 8) sh = $urandom_range(0, 65535);
      else sh = 65535 - $urandom_range(0, 3);
      tp = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 16) : $urandom_range(0, 6);
      r = $urandom_range(0, 19);
      style = (r < 14) ? 0 : (r < 17) ? 1 : 2;
      load_word(addr, 16'(sh));
      load_word(addr + 1, 16'(tp));
      for (int k = 0; k < tp; k++) load_word(addr + 2 + k, pick_coef(style));
      addr += 2 + tp;
      entry_shift.push_back(sh);
      entry_taps.push_back(tp);
    end
  endtask

  // One source row: refresh the pixels each column reads, then compute it.
  task automatic run_row();
    int col;
    for (int j = 0; j < entry_shift.size(); j++) begin
      for (int k = 0; k < entry_taps[j]; k++) begin
        col = entry_shift[j] + k;
        if (col < ROW_PIXELS) load_pixel(col, random_pixel());
      end
      compute();
    end
  endtask

  initial begin
    int random_base;
    int src;
    int rows;
    int dw;
    int r;

    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset config (full row, one row, one column) ----
    // coefficient extremes against saturated pixels
    load_word(0, 16'd0);
    load_word(1, 16'd2);
    load_word(2, 16'h7FFF);
    load_word(3, 16'h8000);
    load_pixel(0, 32'hFFFF_FFFF);
    load_pixel(1, 32'h0000_00FF);
    compute();
    // unity gain tap passes pixel 0 through
    load_word(2, 16'd16384);
    load_word(3, 16'd0);
    compute();
    // zero taps
    load_word(1, 16'd0);
    compute();
    // single most-negative tap clamps to zero
    load_word(1, 16'd1);
    load_word(2, 16'h8000);
    compute();
    // half LSB rounds up: 8192 * 255 lands exactly on a rounding boundary
    load_word(0, 16'd1);
    load_word(2, 16'd8192);
    compute();
    // shift as unsigned 0xFFFF: far past the row, reads zero
    load_word(0, 16'hFFFF);
    compute();
    // top addresses, dropped beats
    load_word(FILTER_WORDS - 1, 16'h5A5A);
    load_pixel(ROW_PIXELS - 1, 32'h8040_2010);
    send(make_beat(ACT_NOP, 14'h3FFF, 16'hFFFF, 32'hFFFF_FFFF), 1'b0);
    send(make_beat(rrf_pkg::ACT_PIXEL, 14'h3FFF, 16'h0000, 32'hDEAD_BEEF), 1'b0);

    // spare register slot is written once and changes nothing
    settle();
    write_reg(CFG_SPARE, rrf_pkg::CFG_W'($urandom));

    // ---- random phases: new config, new entries, a few full rows ----
    random_base = beats_sent;
    while (beats_sent - random_base < RANDOM_BEATS) begin
      r = $urandom_range(0, 9);
      case (r)
        0:       src = 0;
        1:       src = 1;
        2:       src = ROW_PIXELS;
        3:       src = 8191;
        4:       src = $urandom_range(ROW_PIXELS + 1, 8191);
        5, 6:    src = $urandom_range(2, ROW_PIXELS - 1);
        default: src = $urandom_range(2, 24);
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0:       rows = 0;
        1:       rows = 1;
        2:       rows = ROW_PIXELS;
        3:       rows = 8191;
        4:       rows = $urandom_range(2, ROW_PIXELS);
        default: rows = $urandom_range(2, 5);
      endcase
      dw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_config(src, rows, dw);
      // bursts without idling now and then
      no_gaps = ($urandom_range(0, 5) == 0);
      load_entries((dw == 0) ? 1 : dw, src);
      repeat ($urandom_range(1, 3)) run_row();
      no_gaps = 1'b0;
    end

    // ---- drain and verdict ----
    @(negedge clk);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
